// ===== design/bsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the byte to septet packer
// widths, register indexes and the queue entry passed from front to back
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LIMIT_WIDTH = 16;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [6:0] SEPTET_MASK = 7'h7F;
	localparam logic [7:0] HIGH_FLAG   = 8'h80;
	localparam logic [2:0] LAST_PHASE  = 3'd6;
	localparam logic [2:0] GROUP_SIZE  = 3'd7;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	typedef enum logic {
		REG_MODE  = 1'b0,
		REG_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic       two;
		logic [7:0] d0;
		logic       l0;
		logic [7:0] d1;
		logic       l1;
	} bsp_entry_t;

endpackage
`default_nettype wire

// ===== design/bsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_if: stream channels of the packer
// valid/ready channels for input bytes and for result bytes
// ----------------------------------------------------------------------------
interface bsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       last_in;

	modport source (output valid, output data_in, output last_in, input ready);
	modport sink (input valid, input data_in, input last_in, output ready);
endinterface

interface bsp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       last_out;

	modport source (output valid, output data_out, output last_out, input ready);
	modport sink (input valid, input data_out, input last_out, output ready);
endinterface
`default_nettype wire

// ===== design/bsp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_front: accepts input bytes and works out their results
// holds the encoder and decoder message state, pushes one queue entry per
// transaction that produces output
// ----------------------------------------------------------------------------
module bsp_front (
	input  wire                  clk,
	input  wire                  arst_n,
	bsp_in_if.sink               item,
	input  bsp_pkg::mode_t       mode,
	input  wire [15:0]           limit,
	input  wire                  full,
	output logic                 push,
	output bsp_pkg::bsp_entry_t  entry
);

	logic [6:0] carry_q;
	logic [2:0] ccnt_q;
	logic [6:0] prev_q;
	logic       have_q;
	logic [2:0] phase_q;
	logic [bsp_pkg::COUNT_WIDTH-1:0] dcnt_q;

	logic       accept;
	logic [7:0] byte_v;
	logic       last_v;

	// encoder
	logic [2:0] k;
	logic [7:0] shifted;
	logic [7:0] kmask;
	logic [7:0] rest8;
	logic [6:0] septet;
	logic [6:0] rest;

	// decoder
	logic [6:0] s;
	logic [2:0] bits;
	logic [6:0] low;
	logic [7:0] hmask8;
	logic [6:0] high;
	logic [15:0] value16;
	logic       emit;
	logic [bsp_pkg::CMP_WIDTH-1:0] cnt_ext;
	logic [bsp_pkg::CMP_WIDTH-1:0] lim_ext;

	assign item.ready = !full;
	assign accept     = item.valid && !full;
	assign byte_v     = item.data_in;
	assign last_v     = item.last_in;

	always_comb begin
		k       = 3'(ccnt_q + 3'd1);
		shifted = byte_v >> k;
		kmask   = 8'((9'd1 << k) - 9'd1);
		rest8   = 8'((byte_v & kmask) << (bsp_pkg::GROUP_SIZE - k));
		septet  = carry_q | shifted[6:0];
		rest    = rest8[6:0] & bsp_pkg::SEPTET_MASK;
	end

	always_comb begin
		s       = byte_v[6:0];
		bits    = 3'(phase_q + 3'd1);
		low     = s >> (bsp_pkg::LAST_PHASE - phase_q);
		hmask8  = 8'((9'd1 << (bsp_pkg::GROUP_SIZE - phase_q)) - 9'd1);
		high    = prev_q & hmask8[6:0];
		value16 = (16'(high) << bits) | 16'(low);
		cnt_ext = bsp_pkg::CMP_WIDTH'(dcnt_q);
		lim_ext = bsp_pkg::CMP_WIDTH'(limit);
		emit    = (cnt_ext < lim_ext) && (dcnt_q != '1);
	end

	always_comb begin
		entry = '0;
		push  = 1'b0;
		if (mode == bsp_pkg::MODE_ENCODE) begin
			entry.two = last_v || (k == bsp_pkg::GROUP_SIZE);
			entry.d0  = {1'b0, septet} | bsp_pkg::HIGH_FLAG;
			entry.l0  = 1'b0;
			entry.d1  = last_v ? {1'b0, rest} : ({1'b0, rest} | bsp_pkg::HIGH_FLAG);
			entry.l1  = last_v;
			push      = accept;
		end else begin
			entry.two = 1'b0;
			entry.d0  = value16[7:0];
			entry.l0  = last_v;
			push      = accept && have_q && emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			ccnt_q  <= '0;
			prev_q  <= '0;
			have_q  <= 1'b0;
			phase_q <= '0;
			dcnt_q  <= '0;
		end else if (accept) begin
			if (last_v) begin
				carry_q <= '0;
				ccnt_q  <= '0;
				prev_q  <= '0;
				have_q  <= 1'b0;
				phase_q <= '0;
				dcnt_q  <= '0;
			end else if (mode == bsp_pkg::MODE_ENCODE) begin
				if (k == bsp_pkg::GROUP_SIZE) begin
					carry_q <= '0;
					ccnt_q  <= '0;
				end else begin
					carry_q <= rest;
					ccnt_q  <= k;
				end
			end else if (!have_q) begin
				prev_q <= s;
				have_q <= 1'b1;
			end else begin
				if (emit) begin
					dcnt_q <= dcnt_q + 1'b1;
				end
				if (phase_q == bsp_pkg::LAST_PHASE) begin
					phase_q <= '0;
					have_q  <= 1'b0;
					prev_q  <= '0;
				end else begin
					phase_q <= bits;
					prev_q  <= s;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/bsp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_queue: short entry queue between front and back
// register based, one push and one pop per cycle
// ----------------------------------------------------------------------------
module bsp_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  bsp_pkg::bsp_entry_t  wr_entry,
	input  wire                  pop,
	output logic                 full,
	output logic                 empty,
	output bsp_pkg::bsp_entry_t  head
);

	bsp_pkg::bsp_entry_t         mem_q [bsp_pkg::QDEPTH];
	logic [bsp_pkg::QPTR_W-1:0]  wptr_q;
	logic [bsp_pkg::QPTR_W-1:0]  rptr_q;
	logic [bsp_pkg::QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == bsp_pkg::QCNT_W'(bsp_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == bsp_pkg::QPTR_W'(bsp_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == bsp_pkg::QPTR_W'(bsp_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/bsp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_back: drives result transactions from queue entries
// sends the first and, where present, the second byte of the head entry
// ----------------------------------------------------------------------------
module bsp_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bsp_pkg::bsp_entry_t  head,
	input  wire                  empty,
	output logic                 pop,
	bsp_out_if.source            result
);

	logic sel_q;
	logic fire;

	assign result.valid    = !empty;
	assign result.data_out = sel_q ? head.d1 : head.d0;
	assign result.last_out = sel_q ? head.l1 : head.l0;
	assign fire            = result.valid && result.ready;
	assign pop             = fire && (sel_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (fire) begin
			sel_q <= !sel_q && head.two;
		end
	end

endmodule
`default_nettype wire

// ===== design/byte_to_septet_packer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_to_septet_packer_core: 8 to 7 bit stream packer and unpacker
// front computes results per input byte, queue decouples, back emits them
// ----------------------------------------------------------------------------
//  channel   role    payload
//  item      sink    data_in[7:0], last_in
//  result    source  data_out[7:0], last_out
//  apb       slave   mode at 0x0, decode_limit at 0x4
//
//  an input transaction is taken while not full, its first result is offered
//  the next cycle at the earliest; results leave one per cycle while ready is
//  high, so an encode byte with two septets (every seventh byte and a last
//  byte) gives two results; other bytes one, decode septets at most one
//  a two entry queue takes up to two input transactions while results stall
//  asynchronous reset clears message state, mode to encode, limit to 65535
// ----------------------------------------------------------------------------
module byte_to_septet_packer_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bsp_in_if.sink      item,
	bsp_out_if.source   result
);

	bsp_pkg::mode_t       mode_q;
	logic [15:0]          limit_q;
	logic                 wr_en;
	bsp_pkg::reg_idx_t    idx;

	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;
	bsp_pkg::bsp_entry_t  wr_entry;
	bsp_pkg::bsp_entry_t  head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = bsp_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (idx)
			bsp_pkg::REG_MODE:  prdata = {31'b0, mode_q};
			bsp_pkg::REG_LIMIT: prdata = {16'b0, limit_q};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bsp_pkg::MODE_ENCODE;
			limit_q <= 16'hFFFF;
		end else if (wr_en) begin
			unique case (idx)
				bsp_pkg::REG_MODE:  mode_q  <= bsp_pkg::mode_t'(pwdata[0]);
				bsp_pkg::REG_LIMIT: limit_q <= pwdata[15:0];
				default:            ;
			endcase
		end
	end

	bsp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.mode   (mode_q),
		.limit  (limit_q),
		.full   (full),
		.push   (push),
		.entry  (wr_entry)
	);

	bsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	bsp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

// ===== design/bsp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_checker: port level checks of the packer
// result handshake rules and front to back ordering seen at the ports
// ----------------------------------------------------------------------------
module bsp_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_data,
	input wire       out_last
);

	// stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// stalled result payload holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data) && $stable(out_last))
		else $error("result payload changed while stalled");

	// a result only appears after an input transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an input transaction");

	// input is only held off while results are pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind byte_to_septet_packer_core bsp_checker u_bsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data_out),
	.out_last  (result.last_out)
);
`default_nettype wire
